// ===== sv/fwbf_pkg.sv =====
// fwbf_pkg: shared constants and types of the fene/wca bond force pipeline
// no dependencies; used by the interfaces, the divider and the top level
`timescale 1ns / 1ps
`default_nettype none

package fwbf_pkg;

  // restoring divider: one quotient bit per stage plus an input stage
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT = DIV_STEPS + 1;

  // integer square root: one result bit per stage
  localparam int SQRT_STEPS = 32;
  localparam int SQRT_TOP = 62;

  localparam logic [63:0] ONE32 = 64'h0000_0001_0000_0000;
  localparam logic [46:0] FMAX = 47'h7FFF_FFFF_FFFF;
  // 2^(1/6) in q1.30
  localparam logic [30:0] ROOT6_2_Q30 = 31'd1205234447;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REG_MARGIN = 2'd0,
    CFG_LJ_SIGMA   = 2'd1,
    CFG_LJ_ENERGY  = 2'd2
  } cfg_idx_t;

  // partial products of a 64 x 64 multiply
  typedef struct packed {
    logic [63:0] hh;
    logic [63:0] hl;
    logic [63:0] lh;
    logic [63:0] ll;
  } pp_t;

  // geometry carried through the square root
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
    logic             sh;
    logic [30:0]      rmax;
    logic [30:0]      k;
  } geo_t;

  // per-bond context carried alongside the dividers
  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][30:0] mag;
    logic [31:0]      le;
    logic             zero;
    logic [30:0]      r;
    logic [30:0]      rmax;
    logic [30:0]      k;
    logic [61:0]      kr;
    logic             cut;
    logic             negnet;
  } bond_t;

endpackage

`default_nettype wire

// ===== sv/fwbf_if.sv =====
// fwbf_if: valid/ready channel interfaces for bonds, forces and config writes
// depends on fwbf_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fwbf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] first_z;
  logic signed [31:0] second_x;
  logic signed [31:0] second_y;
  logic signed [31:0] second_z;
  logic [30:0]        max_length;
  logic [30:0]        stiffness;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  max_length, stiffness, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                max_length, stiffness, output ready);
endinterface

interface fwbf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_second_x;
  logic signed [47:0] force_second_y;
  logic signed [47:0] force_second_z;
  logic signed [47:0] force_first_x;
  logic signed [47:0] force_first_y;
  logic signed [47:0] force_first_z;
  logic               zero_length;

  modport source (output valid, force_second_x, force_second_y, force_second_z,
                  force_first_x, force_first_y, force_first_z, zero_length, input ready);
  modport sink (input valid, force_second_x, force_second_y, force_second_z,
                force_first_x, force_first_y, force_first_z, zero_length, output ready);
endinterface

interface fwbf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fwbf_pkg::CFG_IDX_W-1:0]  index;
  logic [fwbf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/fene_wca_bond_force_core.sv =====
// fene_wca_bond_force_core: fene spring plus wca repulsion force per bond
// depends on fwbf_pkg, the fwbf channel interfaces and fwbf_div
//
//  channel | dir | transfer                          | payload
//  in_ch   | in  | valid & ready                     | two end positions, rmax, k
//  out_ch  | out | valid & ready                     | forces on both ends, zero flag
//  cfg_ch  | in  | valid & ready (ready always high) | register index, data
//
// one bond enters per cycle unless stalled; the path from input to output register
// runs through the 32-stage square root and three 65-stage divider groups in series.
// reset is synchronous active low, clears valid bits and presets config registers.
// the pipeline moves as one; it stalls only when its last stage and the output
// register are both full and the sink holds ready low, so bubbles still squeeze out.
`timescale 1ns / 1ps
`default_nettype none

module fene_wca_bond_force_core (
  input  logic clk,
  input  logic rst_n,
  fwbf_in_if.sink    in_ch,
  fwbf_out_if.source out_ch,
  fwbf_cfg_if.sink   cfg_ch
);
  import fwbf_pkg::*;

  // 64 x 64 multiply split into four 32 x 32 products
  function automatic pp_t mul_split(logic [63:0] a, logic [63:0] b);
    pp_t p;
    p.hh = 64'(a[63:32]) * 64'(b[63:32]);
    p.hl = 64'(a[63:32]) * 64'(b[31:0]);
    p.lh = 64'(a[31:0]) * 64'(b[63:32]);
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    return p;
  endfunction

  // floor(a*b/2^32) from partial products, saturating
  function automatic logic [63:0] mul32_sat(pp_t p);
    logic [127:0] full;
    full = {p.hh, 64'd0} + {32'd0, p.hl, 32'd0} + {32'd0, p.lh, 32'd0} + {64'd0, p.ll};
    return (full[127:96] != 32'd0) ? '1 : full[95:32];
  endfunction

  // config registers and derived constants
  logic [15:0] margin_r;
  logic [19:0] sigma_r;
  logic [19:0] energy_r;
  logic [39:0] sig_sq_r;
  logic [50:0] sig_cut_r;
  logic [24:0] eps24_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= 16'd7;
      sigma_r  <= 20'd65536;
      energy_r <= 20'd65536;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_REG_MARGIN: margin_r <= cfg_ch.data[15:0];
        CFG_LJ_SIGMA:   sigma_r  <= cfg_ch.data;
        CFG_LJ_ENERGY:  energy_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    sig_sq_r  <= 40'(sigma_r) * 40'(sigma_r);
    sig_cut_r <= 51'(sigma_r) * 51'(ROOT6_2_Q30);
    eps24_r   <= {1'b0, energy_r, 4'd0} + {2'b0, energy_r, 3'd0};
  end

  // pipeline control
  logic                   en;
  logic                   last_vld;
  logic                   out_vld_r;
  logic                   v1_r, v2_r, v4_r, v5_r;
  logic [SQRT_STEPS:0]    vsq_r;
  logic [DIV_LAT-1:0]     vg1_r, vg2_r, vg3_r;
  logic [8:0]             vc_r;
  logic [3:0]             ve_r;

  assign last_vld    = vg3_r[DIV_LAT-1];
  assign en          = !last_vld || !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      vsq_r <= '0; vg1_r <= '0; vg2_r <= '0; vg3_r <= '0;
      vc_r <= '0; ve_r <= '0;
    end else if (en) begin
      v1_r  <= in_ch.valid;
      v2_r  <= v1_r;
      vsq_r <= {vsq_r[SQRT_STEPS-1:0], v2_r};
      v4_r  <= vsq_r[SQRT_STEPS];
      v5_r  <= v4_r;
      vg1_r <= {vg1_r[DIV_LAT-2:0], v5_r};
      vc_r  <= {vc_r[7:0], vg1_r[DIV_LAT-1]};
      vg2_r <= {vg2_r[DIV_LAT-2:0], vc_r[8]};
      ve_r  <= {ve_r[2:0], vg2_r[DIV_LAT-1]};
      vg3_r <= {vg3_r[DIV_LAT-2:0], ve_r[3]};
    end
  end

  // stage 1: separation magnitudes and signs
  logic signed [31:0] p1_w [3];
  logic signed [31:0] p2_w [3];
  logic [32:0]        d_w  [3];
  logic [32:0]        m_w  [3];
  logic [2:0][31:0]   mag1_r;
  logic [2:0]         neg1_r;
  logic [30:0]        rmax1_r, k1_r;

  assign p1_w[0] = in_ch.first_x;
  assign p1_w[1] = in_ch.first_y;
  assign p1_w[2] = in_ch.first_z;
  assign p2_w[0] = in_ch.second_x;
  assign p2_w[1] = in_ch.second_y;
  assign p2_w[2] = in_ch.second_z;

  for (genvar a = 0; a < 3; a++) begin : g_sep
    assign d_w[a] = {p2_w[a][31], p2_w[a]} - {p1_w[a][31], p1_w[a]};
    assign m_w[a] = d_w[a][32] ? (~d_w[a] + 33'd1) : d_w[a];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        mag1_r[a] <= m_w[a][31:0];
        neg1_r[a] <= d_w[a][32];
      end
      rmax1_r <= in_ch.max_length;
      k1_r    <= in_ch.stiffness;
    end
  end

  // stage 2: halve on overflow and square
  logic             sh_w;
  logic [2:0][30:0] hm_w;
  logic [61:0]      sq2_r [3];
  geo_t             geo2_r;

  assign sh_w = mag1_r[0][31] | mag1_r[1][31] | mag1_r[2][31];
  for (genvar a = 0; a < 3; a++) begin : g_half
    assign hm_w[a] = sh_w ? mag1_r[a][31:1] : mag1_r[a][30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < 3; a++) sq2_r[a] <= 62'(hm_w[a]) * 62'(hm_w[a]);
      geo2_r.neg  <= neg1_r;
      geo2_r.mag  <= hm_w;
      geo2_r.sh   <= sh_w;
      geo2_r.rmax <= rmax1_r;
      geo2_r.k    <= k1_r;
    end
  end

  // stage 3 and square root stages
  logic [63:0] x_r   [0:SQRT_STEPS];
  logic [63:0] res_r [0:SQRT_STEPS];
  geo_t        geo_r [0:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= {2'd0, sq2_r[0]} + {2'd0, sq2_r[1]} + {2'd0, sq2_r[2]};
      res_r[0] <= '0;
      geo_r[0] <= geo2_r;
    end
  end

  for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] SBIT = 64'd1 << (SQRT_TOP - 2 * (j - 1));
    logic [63:0] trial_w;
    logic        hit_w;

    assign trial_w = res_r[j-1] + SBIT;
    assign hit_w   = x_r[j-1] >= trial_w;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j]   <= hit_w ? (x_r[j-1] - trial_w) : x_r[j-1];
        res_r[j] <= hit_w ? ((res_r[j-1] >> 1) + SBIT) : (res_r[j-1] >> 1);
        geo_r[j] <= geo_r[j-1];
      end
    end
  end

  // stage 4: length clamp
  geo_t        gend_w;
  logic [31:0] le_w;
  logic [32:0] len_w;
  logic [30:0] rmaxf_w, lim_w, r_w;
  bond_t       bond4_r;

  assign gend_w  = geo_r[SQRT_STEPS];
  assign le_w    = res_r[SQRT_STEPS][31:0];
  assign len_w   = gend_w.sh ? {le_w, 1'b0} : {1'b0, le_w};
  assign rmaxf_w = (gend_w.rmax == 31'd0) ? 31'd1 : gend_w.rmax;
  assign lim_w   = (rmaxf_w > {15'd0, margin_r}) ? (rmaxf_w - {15'd0, margin_r}) : 31'd1;
  assign r_w     = (len_w < {2'd0, lim_w}) ? len_w[30:0] : lim_w;

  always_ff @(posedge clk) begin
    if (en) begin
      bond4_r.neg    <= gend_w.neg;
      bond4_r.mag    <= gend_w.mag;
      bond4_r.le     <= le_w;
      bond4_r.zero   <= (le_w == 32'd0);
      bond4_r.r      <= r_w;
      bond4_r.rmax   <= rmaxf_w;
      bond4_r.k      <= gend_w.k;
      bond4_r.kr     <= '0;
      bond4_r.cut    <= 1'b0;
      bond4_r.negnet <= 1'b0;
    end
  end

  // stage 5: k*r, r*r and wca cutoff
  bond_t       bond5_w;
  bond_t       bond5_r;
  logic [61:0] rr5_r;

  always_comb begin
    bond5_w     = bond4_r;
    bond5_w.kr  = 62'(bond4_r.k) * 62'(bond4_r.r);
    bond5_w.cut = {bond4_r.r, 30'd0} < {10'd0, sig_cut_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bond5_r <= bond5_w;
      rr5_r   <= 62'(bond4_r.r) * 62'(bond4_r.r);
    end
  end

  // divider group one: q = r/rmax and rho2 = sigma^2/r^2
  logic [63:0] quo_q, quo_rho;
  bond_t       g1_r [0:DIV_LAT-1];

  fwbf_div u_div_q (
    .clk(clk), .en(en),
    .num_hi(64'd0), .num_lo({1'b0, bond5_r.r, 32'd0}),
    .dvs({33'd0, bond5_r.rmax}), .quo(quo_q)
  );

  fwbf_div u_div_rho (
    .clk(clk), .en(en),
    .num_hi({56'd0, sig_sq_r[39:32]}), .num_lo({sig_sq_r[31:0], 32'd0}),
    .dvs({2'd0, rr5_r}), .quo(quo_rho)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      g1_r[0] <= bond5_r;
      for (int i = 1; i < DIV_LAT; i++) g1_r[i] <= g1_r[i-1];
    end
  end

  // chain stages: fene denominator and 24*eps*rho^6*(2*rho^6 - 1)
  bond_t        bc_r [1:9];
  logic [65:0]  qq1_r;
  pp_t          pp1_r, pp3_r, pp6_r;
  logic [63:0]  rho2_1_r, rho2_2_r, a2_r, rho6_4_r, rho6_5_r, t5_r, term7_r;
  logic [32:0]  den_r [2:9];
  logic [56:0]  plo8_r, phi8_r;
  logic [88:0]  prod9_r;
  logic [33:0]  q2_w;

  assign q2_w = qq1_r[65:32];

  always_ff @(posedge clk) begin
    if (en) begin
      bc_r[1] <= g1_r[DIV_LAT-1];
      for (int i = 2; i <= 9; i++) bc_r[i] <= bc_r[i-1];
      // c1
      qq1_r    <= 66'(quo_q[32:0]) * 66'(quo_q[32:0]);
      pp1_r    <= mul_split(quo_rho, quo_rho);
      rho2_1_r <= quo_rho;
      // c2
      den_r[2] <= (q2_w[33:32] == 2'd0) ? (ONE32[32:0] - q2_w[32:0]) : 33'd1;
      a2_r     <= mul32_sat(pp1_r);
      rho2_2_r <= rho2_1_r;
      for (int i = 3; i <= 9; i++) den_r[i] <= den_r[i-1];
      // c3, c4
      pp3_r    <= mul_split(a2_r, rho2_2_r);
      rho6_4_r <= mul32_sat(pp3_r);
      // c5
      rho6_5_r <= rho6_4_r;
      if (rho6_4_r[63]) begin
        t5_r <= '1 - ONE32;
      end else if ({rho6_4_r[62:0], 1'b0} > ONE32) begin
        t5_r <= {rho6_4_r[62:0], 1'b0} - ONE32;
      end else begin
        t5_r <= '0;
      end
      // c6, c7
      pp6_r   <= mul_split(rho6_5_r, t5_r);
      term7_r <= mul32_sat(pp6_r);
      // c8, c9
      plo8_r  <= 57'(eps24_r) * 57'(term7_r[31:0]);
      phi8_r  <= 57'(eps24_r) * 57'(term7_r[63:32]);
      prod9_r <= {phi8_r, 32'd0} + {32'd0, plo8_r};
    end
  end

  // divider group two: fene magnitude and wca magnitude
  logic [63:0] quo_fs, quo_lj;
  bond_t       g2_r [0:DIV_LAT-1];

  fwbf_div u_div_fs (
    .clk(clk), .en(en),
    .num_hi({42'd0, bc_r[9].kr[61:40]}), .num_lo({bc_r[9].kr[39:0], 24'd0}),
    .dvs({31'd0, den_r[9]}), .quo(quo_fs)
  );

  fwbf_div u_div_lj (
    .clk(clk), .en(en),
    .num_hi({39'd0, prod9_r[88:64]}), .num_lo(prod9_r[63:0]),
    .dvs({25'd0, bc_r[9].r, 8'd0}), .quo(quo_lj)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      g2_r[0] <= bc_r[9];
      for (int i = 1; i < DIV_LAT; i++) g2_r[i] <= g2_r[i-1];
    end
  end

  // net scalar force and component numerators
  bond_t       be_r [1:4];
  bond_t       be2_w;
  logic [46:0] fs1_r, lj1_r, mnet2_r;
  logic [47:0] net_w;
  logic [54:0] plo3_r [3];
  logic [53:0] phi3_r [3];
  logic [77:0] prod4_r [3];

  assign net_w = {1'b0, lj1_r} - {1'b0, fs1_r};

  // e2 context picks up the sign of the net force
  always_comb begin
    be2_w        = be_r[1];
    be2_w.negnet = net_w[47];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      be_r[1] <= g2_r[DIV_LAT-1];
      be_r[2] <= be2_w;
      for (int i = 3; i <= 4; i++) be_r[i] <= be_r[i-1];
      // e1: saturate both terms, wca only inside the cutoff
      fs1_r <= (quo_fs > {17'd0, FMAX}) ? FMAX : quo_fs[46:0];
      if (!g2_r[DIV_LAT-1].cut) begin
        lj1_r <= '0;
      end else begin
        lj1_r <= (quo_lj > {17'd0, FMAX}) ? FMAX : quo_lj[46:0];
      end
      // e2: magnitude of the net force
      mnet2_r <= net_w[47] ? (~net_w[46:0] + 47'd1) : net_w[46:0];
      // e3, e4: |F| * |d_i|
      for (int a = 0; a < 3; a++) begin
        plo3_r[a]  <= 55'(mnet2_r[23:0]) * 55'(be_r[2].mag[a]);
        phi3_r[a]  <= 54'(mnet2_r[46:24]) * 54'(be_r[2].mag[a]);
        prod4_r[a] <= {phi3_r[a], 24'd0} + {23'd0, plo3_r[a]};
      end
    end
  end

  // divider group three: components over the length
  logic [63:0] quo_c [3];
  bond_t       g3_r [0:DIV_LAT-1];

  for (genvar a = 0; a < 3; a++) begin : g_comp
    fwbf_div u_div_c (
      .clk(clk), .en(en),
      .num_hi({50'd0, prod4_r[a][77:64]}), .num_lo(prod4_r[a][63:0]),
      .dvs({32'd0, be_r[4].le}), .quo(quo_c[a])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g3_r[0] <= be_r[4];
      for (int i = 1; i < DIV_LAT; i++) g3_r[i] <= g3_r[i-1];
    end
  end

  // final saturation and signs
  bond_t       bend_w;
  logic [46:0] cm_w  [3];
  logic [47:0] fsec_w [3];
  logic [47:0] ffir_w [3];

  assign bend_w = g3_r[DIV_LAT-1];

  for (genvar a = 0; a < 3; a++) begin : g_sign
    logic flip_w;
    assign cm_w[a]   = (quo_c[a] > {17'd0, FMAX}) ? FMAX : quo_c[a][46:0];
    assign flip_w    = bend_w.negnet != bend_w.neg[a];
    assign fsec_w[a] = bend_w.zero ? 48'd0 :
                       (flip_w ? (48'd0 - {1'b0, cm_w[a]}) : {1'b0, cm_w[a]});
    assign ffir_w[a] = bend_w.zero ? 48'd0 :
                       (flip_w ? {1'b0, cm_w[a]} : (48'd0 - {1'b0, cm_w[a]}));
  end

  // output register
  logic [47:0] fsec_r [3];
  logic [47:0] ffir_r [3];
  logic        zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      out_vld_r <= last_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_ch.ready) begin
      for (int a = 0; a < 3; a++) begin
        fsec_r[a] <= fsec_w[a];
        ffir_r[a] <= ffir_w[a];
      end
      zero_r <= bend_w.zero;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.force_second_x = fsec_r[0];
  assign out_ch.force_second_y = fsec_r[1];
  assign out_ch.force_second_z = fsec_r[2];
  assign out_ch.force_first_x  = ffir_r[0];
  assign out_ch.force_first_y  = ffir_r[1];
  assign out_ch.force_first_z  = ffir_r[2];
  assign out_ch.zero_length    = zero_r;

  // checks
  a_zero_forces: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && zero_r |-> fsec_r[0] == 48'd0 && fsec_r[1] == 48'd0 &&
                            fsec_r[2] == 48'd0 && ffir_r[0] == 48'd0)
    else $error("zero length result with nonzero force");

  a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> ffir_r[0] == 48'd0 - fsec_r[0] && ffir_r[1] == 48'd0 - fsec_r[1] &&
                  ffir_r[2] == 48'd0 - fsec_r[2])
    else $error("first end force is not the negation of the second");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !en |-> last_vld && out_vld_r && !out_ch.ready)
    else $error("pipeline stalled without a blocked output");

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> last_vld && out_vld_r)
    else $error("item lost during a stall");

endmodule

`default_nettype wire

// ===== sv/fwbf_div.sv =====
// fwbf_div: pipelined restoring divider, floor({num_hi,num_lo}/dvs), saturating
// depends on fwbf_pkg; every stage advances when en is high
`timescale 1ns / 1ps
`default_nettype none

module fwbf_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num_hi,
  input  logic [63:0] num_lo,
  input  logic [63:0] dvs,
  output logic [63:0] quo
);
  import fwbf_pkg::*;

  logic [63:0] rem_r [0:DIV_STEPS];
  logic [63:0] lo_r  [0:DIV_STEPS];
  logic [63:0] quo_r [0:DIV_STEPS];
  logic [63:0] dvs_r [0:DIV_STEPS];
  logic        sat_r [0:DIV_STEPS];

  // input stage: overflow and zero divisor saturate
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_hi;
      lo_r[0]  <= num_lo;
      quo_r[0] <= '0;
      dvs_r[0] <= dvs;
      sat_r[0] <= (dvs == 64'd0) || (num_hi >= dvs);
    end
  end

  // one quotient bit per stage
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    logic [64:0] sh_w;
    logic [64:0] dif_w;
    logic        take_w;

    assign sh_w   = {rem_r[j-1], lo_r[j-1][63]};
    assign dif_w  = sh_w - {1'b0, dvs_r[j-1]};
    assign take_w = sh_w >= {1'b0, dvs_r[j-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take_w ? dif_w[63:0] : sh_w[63:0];
        lo_r[j]  <= {lo_r[j-1][62:0], 1'b0};
        quo_r[j] <= {quo_r[j-1][62:0], take_w};
        dvs_r[j] <= dvs_r[j-1];
        sat_r[j] <= sat_r[j-1];
      end
    end
  end

  assign quo = sat_r[DIV_STEPS] ? '1 : quo_r[DIV_STEPS];

endmodule

`default_nettype wire

// ===== tb/fene_wca_bond_force_core_tb.sv =====
// fene_wca_bond_force_core_tb: bond force check with a fixed-point force predictor
// depends on fwbf_pkg, the fwbf channel interfaces and fene_wca_bond_force_core
`timescale 1ns / 1ps

module fene_wca_bond_force_core_tb;
  import fwbf_pkg::*;

  localparam longint unsigned Q32_ONE = 64'h1_0000_0000;
  localparam longint unsigned FORCE_MAX = (64'd1 << 47) - 1;
  localparam longint unsigned SAT64 = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned ROOT6_Q30 = 64'd1205234447;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic signed [31:0] p1[3];
    logic signed [31:0] p2[3];
    logic [30:0]        rmax;
    logic [30:0]        k;
  } spring_t;

  typedef struct {
    logic [47:0] f[6];
    logic        zero;
  } bond_force_t;

  // fixed-point helpers
  function automatic longint unsigned mul_q32(longint unsigned a, longint unsigned b);
    bit [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    if (p[127:96] != 0) return SAT64;
    return p[95:32];
  endfunction

  function automatic longint unsigned mul_div(longint unsigned a, longint unsigned b,
                                              longint unsigned c);
    bit [127:0] p;
    bit [127:0] q;
    if (c == 0) return SAT64;
    p = {64'b0, a} * {64'b0, b};
    if (p[127:64] >= c) return SAT64;
    q = p / {64'b0, c};
    return q[63:0];
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  class force_scoreboard;
    longint unsigned margin = 7;
    longint unsigned sigma = 65536;
    longint unsigned energy = 65536;
    bond_force_t pending_forces[$];
    int errors = 0;
    int checked = 0;
    int zero_seen = 0;

    function bond_force_t predict(spring_t b);
      bond_force_t res;
      longint unsigned mag[3];
      bit neg[3];
      bit big;
      longint dd, net;
      longint unsigned sum, le, len, rmax, kk, lim, r, q, q2, den, fs, lj, mnet, m;
      longint unsigned rho2, rho6, two, t, term;
      int s;
      big = 0;
      sum = 0;
      lj = 0;
      for (int a = 0; a < 3; a++) begin
        dd = longint'(b.p2[a]) - longint'(b.p1[a]);
        neg[a] = dd < 0;
        mag[a] = neg[a] ? -dd : dd;
        if (mag[a] >= (64'd1 << 31)) big = 1;
      end
      s = big ? 1 : 0;
      for (int a = 0; a < 3; a++) begin
        mag[a] >>= s;
        sum += mag[a] * mag[a];
      end
      le = int_sqrt(sum);
      if (le == 0) begin
        foreach (res.f[i]) res.f[i] = '0;
        res.zero = 1;
        return res;
      end
      len = le << s;
      rmax = b.rmax;
      if (rmax == 0) rmax = 1;
      kk = b.k;
      lim = rmax > margin ? rmax - margin : 1;
      r = len < lim ? len : lim;
      // spring attraction
      q = (r << 32) / rmax;
      q2 = mul_q32(q, q);
      den = q2 < Q32_ONE ? Q32_ONE - q2 : 1;
      fs = mul_div(kk * r, 64'd1 << 24, den);
      if (fs > FORCE_MAX) fs = FORCE_MAX;
      // repulsion inside the cutoff
      if ((r << 30) < sigma * ROOT6_Q30) begin
        rho2 = mul_div(sigma * sigma, Q32_ONE, r * r);
        rho6 = mul_q32(mul_q32(rho2, rho2), rho2);
        two = rho6 >= (64'd1 << 63) ? SAT64 : rho6 << 1;
        t = two > Q32_ONE ? two - Q32_ONE : 0;
        term = mul_q32(rho6, t);
        lj = mul_div(24 * energy, term, r << 8);
        if (lj > FORCE_MAX) lj = FORCE_MAX;
      end
      net = longint'(lj) - longint'(fs);
      mnet = net < 0 ? -net : net;
      for (int a = 0; a < 3; a++) begin
        m = mul_div(mnet, mag[a], le);
        if (m > FORCE_MAX) m = FORCE_MAX;
        dd = ((net < 0) != neg[a]) ? -longint'(m) : longint'(m);
        res.f[a] = dd[47:0];
        dd = -dd;
        res.f[3 + a] = dd[47:0];
      end
      res.zero = 0;
      return res;
    endfunction

    function void note_spring(spring_t b);
      pending_forces.insert(pending_forces.size(), predict(b));
    endfunction

    function void check_force(bond_force_t got);
      bond_force_t exp_f;
      string names[6] = '{"second_x", "second_y", "second_z",
                          "first_x", "first_y", "first_z"};
      checked++;
      if (got.zero) zero_seen++;
      if (pending_forces.size() == 0) begin
        $display("%0t: unexpected force transfer, nothing pending", $time);
        errors++;
        return;
      end
      exp_f = pending_forces.pop_front();
      foreach (names[i])
        if (got.f[i] !== exp_f.f[i]) begin
          $display("%0t: force_%s expected %h actual %h", $time, names[i], exp_f.f[i],
                   got.f[i]);
          errors++;
        end
      if (got.zero !== exp_f.zero) begin
        $display("%0t: zero_length expected %b actual %b", $time, exp_f.zero, got.zero);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  fwbf_in_if in_ch();
  fwbf_out_if out_ch();
  fwbf_cfg_if cfg_ch();
  force_scoreboard sb = new();
  int unsigned cyc = 0;
  int sent = 0;
  int burst_left = 0;
  bit long_hold_done = 0;

  fene_wca_bond_force_core u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // clock
  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // known values from time zero
  initial begin
    in_ch.valid = 0;
    in_ch.first_x = 0;
    in_ch.first_y = 0;
    in_ch.first_z = 0;
    in_ch.second_x = 0;
    in_ch.second_y = 0;
    in_ch.second_z = 0;
    in_ch.max_length = 0;
    in_ch.stiffness = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = CFG_REG_MARGIN;
    cfg_ch.data = 0;
  end

  // result sink with its own stall pattern and one long hold-off early in the
  // first random phase, while plenty of springs are still to come
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      cyc++;
      if (!long_hold_done && sent >= 30) begin
        long_hold_done = 1;
        out_ch.ready <= 0;
        repeat (800) @(posedge clk);
      end else begin
        case ((cyc / 97) % 4)
          0: out_ch.ready <= 1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= (cyc % 4 == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // result monitor, sampled mid-cycle
  always @(negedge clk) begin
    bond_force_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.f[0] = out_ch.force_second_x;
      got.f[1] = out_ch.force_second_y;
      got.f[2] = out_ch.force_second_z;
      got.f[3] = out_ch.force_first_x;
      got.f[4] = out_ch.force_first_y;
      got.f[5] = out_ch.force_first_z;
      got.zero = out_ch.zero_length;
      sb.check_force(got);
    end
  end

  function automatic spring_t mk_spring(int x1, int y1, int z1, int x2, int y2, int z2,
                                        int unsigned rmax, int unsigned k);
    spring_t b;
    b.p1 = '{x1, y1, z1};
    b.p2 = '{x2, y2, z2};
    b.rmax = rmax[30:0];
    b.k = k[30:0];
    return b;
  endfunction

  function automatic spring_t rand_spring();
    spring_t b;
    int unsigned scale;
    int mode;
    mode = $urandom_range(0, 19);
    scale = 32'd1 << $urandom_range(6, 20);
    for (int a = 0; a < 3; a++) begin
      b.p1[a] = $urandom;
      if (mode == 0) b.p2[a] = b.p1[a];
      else if (mode < 3) b.p2[a] = $urandom;
      else b.p2[a] = b.p1[a] + int'($urandom_range(0, 2 * scale)) - int'(scale);
    end
    case ($urandom_range(0, 3))
      0: b.rmax = 31'($urandom);
      1: b.rmax = 31'($urandom_range(0, 255));
      default: b.rmax = 31'(scale * $urandom_range(1, 4) + $urandom_range(0, scale));
    endcase
    b.k = 31'($urandom >> $urandom_range(0, 31));
    return b;
  endfunction

  // one spring transfer; valid stays high within a burst
  task automatic send_spring(spring_t b);
    bit hs;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.first_x <= b.p1[0];
    in_ch.first_y <= b.p1[1];
    in_ch.first_z <= b.p1[2];
    in_ch.second_x <= b.p2[0];
    in_ch.second_y <= b.p2[1];
    in_ch.second_z <= b.p2[2];
    in_ch.max_length <= b.rmax;
    in_ch.stiffness <= b.k;
    do begin
      @(negedge clk);
      hs = in_ch.ready;
      @(posedge clk);
    end while (!hs);
    sb.note_spring(b);
    sent++;
  endtask

  // wait for all pending forces, then let the pipeline settle
  task automatic drain();
    in_ch.valid <= 0;
    burst_left = 0;
    while (sb.pending_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one register write; valid is dropped by the caller after the last one
  task automatic write_reg(cfg_idx_t idx, int unsigned value);
    bit hs;
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value[19:0];
    do begin
      @(negedge clk);
      hs = cfg_ch.ready;
      @(posedge clk);
    end while (!hs);
    case (idx)
      CFG_REG_MARGIN: sb.margin = value & 32'hFFFF;
      CFG_LJ_SIGMA:   sb.sigma = value & 32'hFFFFF;
      default:        sb.energy = value & 32'hFFFFF;
    endcase
  endtask

  task automatic set_regs(int unsigned margin, int unsigned sigma, int unsigned energy);
    write_reg(CFG_REG_MARGIN, margin);
    write_reg(CFG_LJ_SIGMA, sigma);
    write_reg(CFG_LJ_ENERGY, energy);
    cfg_ch.valid <= 0;
  endtask

  task automatic send_directed();
    spring_t list[15];
    list[0] = mk_spring(5, -7, 9, 5, -7, 9, 65536, 65536);          // coinciding ends
    list[1] = mk_spring(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF);             // largest separation
    list[2] = mk_spring(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1000, 1);
    list[3] = mk_spring(0, 0, 0, 65536, 0, 0, 0, 65536);            // zero rmax
    list[4] = mk_spring(0, 0, 0, 0, 1, 0, 3, 65536);                // margin above rmax
    list[5] = mk_spring(0, 0, 0, 0, 0, 65536, 65543, 65536);        // margin equals gap
    list[6] = mk_spring(0, 0, 0, 3 << 16, 0, 0, 2 << 16, 65536);    // past rmax
    list[7] = mk_spring(0, 0, 0, 1 << 16, 1 << 16, 0, 93000, 31'h7FFF_FFFF);
    list[8] = mk_spring(0, 0, 0, 1, 0, 0, 31'h7FFF_FFFF, 65536);    // deep repulsion
    list[9] = mk_spring(0, 0, 0, 0, -65536, 0, 31'h7FFF_FFFF, 0);   // zero stiffness
    list[10] = mk_spring(100, 200, 300, 100 + 73562, 200, 300, 10 << 16, 65536);
    list[11] = mk_spring(0, 0, 0, 73563, 0, 0, 10 << 16, 65536);    // just past cutoff
    list[12] = mk_spring(0, 0, 0, -40000, 30000, -20000, 5 << 16, 200000);
    list[13] = mk_spring(-1, -1, -1, 0, 0, 0, 1, 1);
    list[14] = mk_spring(32'h7FFF_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 70000, 65536);
    foreach (list[i]) send_spring(list[i]);
  endtask

  task automatic send_random(int n);
    repeat (n) send_spring(rand_spring());
  endtask

  // main sequence: reset, then phases of configuration and stimulus
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_directed();
    send_random(300);
    drain();
    set_regs(0, 1, 0);
    send_directed();
    send_random(200);
    drain();
    set_regs(65535, 1048575, 1048575);
    send_directed();
    send_random(200);
    drain();
    set_regs($urandom_range(0, 65535), 0, $urandom_range(0, 1048575));
    send_random(100);
    drain();
    set_regs($urandom_range(0, 65535), $urandom_range(1, 1048575),
             $urandom_range(0, 1048575));
    send_random(150);
    drain();
    set_regs(7, 65536, 65536);
    send_random(150);
    drain();
    $display("sent %0d springs over six register settings, %0d force transfers checked",
             sent, sb.checked);
    $display("%0d coinciding-end results, %0d mismatches", sb.zero_seen, sb.errors);
    if (sb.errors == 0 && sb.checked == sent) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d forces pending", sb.pending_forces.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== fene_wca_bond_force_core.f =====
sv/fwbf_pkg.sv
sv/fwbf_if.sv
sv/fwbf_div.sv
sv/fene_wca_bond_force_core.sv
tb/fene_wca_bond_force_core_tb.sv
